// ===== rtl/fpba_pkg.sv =====
package fpba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    // wide enough for the saturated block count and the 5-bit register
    localparam int CNT_BITS   = (IDX_BITS + 1 > 5) ? IDX_BITS + 1 : 5;

    // cycles from an accepted allocate to the edge that takes its result
    localparam int ALLOC_DELAY = MAX_BLOCKS + 2;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic                 valid;
        logic [SIZE_BITS-1:0] amount;
        logic                 found;
        logic [IDX_BITS-1:0]  pick;
        logic [SIZE_BITS-1:0] pick_val;
    } t_probe;

    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] val;
    } t_write;

    typedef struct packed {
        logic [1:0] policy;
        logic [4:0] count;
    } t_cfg;

endpackage

// ===== rtl/fit_policy_block_allocator.sv =====
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+-------------------------------------
// command   | in        | start, busy               | i_mode, i_block_index, i_amount
// result    | out       | o_done (one-cycle strobe) | o_granted, o_chosen_block, o_size_left
// config    | in/out    | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// a load writes its entry at accept, and the result strobes in the cycle after.
// an allocate sends a search probe that walks the cell row one cell per cycle, then
// the chosen cell is written back as the result is registered.
// reset is synchronous, active low, and clears every table entry at once.
// busy is high only while an allocate is in the row; the receiver cannot stall results.
module fit_policy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [3:0]  i_block_index,
    input  logic [15:0] i_amount,
    output logic        o_done,
    output logic        o_granted,
    output logic [3:0]  o_chosen_block,
    output logic [15:0] o_size_left,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fpba_pkg::t_cfg                  w_cfg;
    fpba_pkg::t_probe                w_probe [fpba_pkg::MAX_BLOCKS+1];
    fpba_pkg::t_probe                r_inject;
    fpba_pkg::t_probe                w_end;
    fpba_pkg::t_write                w_wr;
    logic [fpba_pkg::CNT_BITS-1:0]   w_count;
    logic [fpba_pkg::SIZE_BITS-1:0]  w_amt;
    logic [fpba_pkg::SIZE_BITS-1:0]  w_left_val;
    logic                            w_accept;
    logic                            w_in_range;
    logic                            r_busy;
    logic                            r_done;
    logic                            r_granted;
    logic [3:0]                      r_chosen;
    logic [15:0]                     r_left;

    fpba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_count = (int'(w_cfg.count) > fpba_pkg::MAX_BLOCKS) ?
                     fpba_pkg::CNT_BITS'(fpba_pkg::MAX_BLOCKS) :
                     fpba_pkg::CNT_BITS'(w_cfg.count);

    assign w_probe[0] = r_inject;

    for (genvar k = 0; k < fpba_pkg::MAX_BLOCKS; k++) begin : g_cell
        fpba_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (fpba_pkg::IDX_BITS'(k)),
            .i_count  (w_count),
            .i_policy (w_cfg.policy),
            .i_probe  (w_probe[k]),
            .i_wr     (w_wr),
            .o_probe  (w_probe[k+1])
        );
    end

    assign w_end      = w_probe[fpba_pkg::MAX_BLOCKS];
    assign w_accept   = start && !r_busy;
    assign w_amt      = fpba_pkg::SIZE_BITS'(i_amount);
    assign w_in_range = int'(i_block_index) < fpba_pkg::MAX_BLOCKS;
    assign w_left_val = w_end.pick_val - w_end.amount;

    // loads write at accept; allocates write back when the probe leaves the row
    always_comb begin
        w_wr = '0;
        if (w_accept && (i_mode == fpba_pkg::MODE_LOAD) && w_in_range) begin
            w_wr.en  = 1'b1;
            w_wr.idx = fpba_pkg::IDX_BITS'(i_block_index);
            w_wr.val = w_amt;
        end else if (w_end.valid && w_end.found) begin
            w_wr.en  = 1'b1;
            w_wr.idx = w_end.pick;
            w_wr.val = w_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_done         <= 1'b0;
            r_inject.valid <= 1'b0;
        end else begin
            r_done         <= 1'b0;
            r_inject.valid <= 1'b0;
            if (w_accept) begin
                if (i_mode == fpba_pkg::MODE_LOAD) begin
                    r_done    <= 1'b1;
                    r_granted <= 1'b0;
                    r_chosen  <= i_block_index;
                    r_left    <= w_in_range ? 16'(w_amt) : 16'd0;
                end else begin
                    r_busy            <= 1'b1;
                    r_inject.valid    <= 1'b1;
                    r_inject.amount   <= w_amt;
                    r_inject.found    <= 1'b0;
                    r_inject.pick     <= '0;
                    r_inject.pick_val <= '0;
                end
            end
            if (w_end.valid) begin
                r_busy    <= 1'b0;
                r_done    <= 1'b1;
                r_granted <= w_end.found;
                r_chosen  <= w_end.found ? 4'(w_end.pick) : 4'd0;
                r_left    <= w_end.found ? 16'(w_left_val) : 16'd0;
            end
        end
    end

    assign busy           = r_busy;
    assign o_done         = r_done;
    assign o_granted      = r_granted;
    assign o_chosen_block = r_chosen;
    assign o_size_left    = r_left;

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == fpba_pkg::MODE_LOAD)) |=> (o_done && !o_granted))
        else $error("load transaction did not report on the next cycle");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == fpba_pkg::MODE_ALLOC))
            |-> ##(fpba_pkg::ALLOC_DELAY) (o_done && $fell(busy)))
        else $error("allocate transaction result not seen after the cell row");

    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> r_busy)
        else $error("search probe left the row while idle");

endmodule

// ===== rtl/fpba_cell.sv =====
module fpba_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [fpba_pkg::IDX_BITS-1:0]      i_index,
    input  logic [fpba_pkg::CNT_BITS-1:0]      i_count,
    input  logic [1:0]                         i_policy,
    input  fpba_pkg::t_probe                   i_probe,
    input  fpba_pkg::t_write                   i_wr,
    output fpba_pkg::t_probe                   o_probe
);

    logic [fpba_pkg::SIZE_BITS-1:0] r_free;
    fpba_pkg::t_probe               r_probe;
    fpba_pkg::t_probe               n_probe;
    logic                           w_active;
    logic                           w_fits;
    logic                           w_better;
    logic                           w_take;

    always_comb begin
        w_active = fpba_pkg::CNT_BITS'(i_index) < i_count;
        w_fits   = i_probe.valid && w_active && (r_free >= i_probe.amount);
        w_better = ((i_policy == fpba_pkg::POLICY_BEST)  && (r_free < i_probe.pick_val)) ||
                   ((i_policy == fpba_pkg::POLICY_WORST) && (r_free > i_probe.pick_val));
        // first fit never replaces a pick once one is found
        w_take   = w_fits && (!i_probe.found || w_better);
        n_probe  = i_probe;
        n_probe.found = i_probe.found | w_fits;
        if (w_take) begin
            n_probe.pick     = i_index;
            n_probe.pick_val = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free        <= '0;
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (i_wr.en && (i_wr.idx == i_index)) begin
                r_free <= i_wr.val;
            end
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/fpba_cfg.sv =====
module fpba_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fpba_pkg::t_cfg    o_cfg
);

    logic [1:0] r_policy;
    logic [4:0] r_count;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpba_pkg::POLICY_FIRST;
            r_count  <= fpba_pkg::BLOCK_COUNT_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                fpba_pkg::REG_FIT_POLICY:  r_policy <= pwdata[1:0];
                fpba_pkg::REG_BLOCK_COUNT: r_count  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fpba_pkg::REG_FIT_POLICY:  prdata = {30'd0, r_policy};
            fpba_pkg::REG_BLOCK_COUNT: prdata = {27'd0, r_count};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.policy = r_policy;
    assign o_cfg.count  = r_count;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // policy code with no meaning of its own, falls back to first fit
    localparam logic [1:0] POLICY_SPARE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 140;

    typedef struct packed {
        logic                           granted;
        logic [fpba_pkg::IDX_BITS-1:0]  block;
        logic [fpba_pkg::SIZE_BITS-1:0] left;
    } t_alloc_result;

    class t_alloc_tracker;
        logic [fpba_pkg::SIZE_BITS-1:0] free_size [fpba_pkg::MAX_BLOCKS];
        logic [1:0]                     policy;
        logic [4:0]                     count;
        t_alloc_result                  expected_results [$];
        int                             errors;
        int                             loads;
        int                             allocs;
        int                             grants;

        function new();
            foreach (free_size[i]) free_size[i] = '0;
            policy = fpba_pkg::POLICY_FIRST;
            count  = fpba_pkg::BLOCK_COUNT_RESET;
            errors = 0;
            loads  = 0;
            allocs = 0;
            grants = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function t_alloc_result predict_alloc(logic mode,
                                              logic [fpba_pkg::IDX_BITS-1:0] idx,
                                              logic [fpba_pkg::SIZE_BITS-1:0] amt);
            t_alloc_result r;
            int            n;
            int            pick;
            bit            found;
            r     = '0;
            pick  = 0;
            found = 1'b0;
            if (mode == fpba_pkg::MODE_LOAD) begin
                free_size[idx] = amt;
                r.block = idx;
                r.left  = amt;
                loads++;
            end else begin
                allocs++;
                n = (count > fpba_pkg::MAX_BLOCKS) ? fpba_pkg::MAX_BLOCKS : count;
                for (int i = 0; i < n; i++) begin
                    if (free_size[i] >= amt) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                        end else if (policy == fpba_pkg::POLICY_BEST &&
                                     free_size[i] < free_size[pick]) begin
                            pick = i;
                        end else if (policy == fpba_pkg::POLICY_WORST &&
                                     free_size[i] > free_size[pick]) begin
                            pick = i;
                        end
                    end
                end
                if (found) begin
                    free_size[pick] = free_size[pick] - amt;
                    r.granted = 1'b1;
                    r.block   = pick[fpba_pkg::IDX_BITS-1:0];
                    r.left    = free_size[pick];
                    grants++;
                end
            end
            return r;
        endfunction

        function void note_command(logic mode, logic [fpba_pkg::IDX_BITS-1:0] idx,
                                   logic [fpba_pkg::SIZE_BITS-1:0] amt);
            expected_results.push_back(predict_alloc(mode, idx, amt));
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result granted %0d block %0d left %0d",
                         $time, got.granted, got.block, got.left);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.granted !== want.granted) begin
                $display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
                errors++;
            end
            if (got.block !== want.block) begin
                $display("%0t: chosen_block expected %0d actual %0d", $time, want.block, got.block);
                errors++;
            end
            if (got.left !== want.left) begin
                $display("%0t: size_left expected %0d actual %0d", $time, want.left, got.left);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = fpba_pkg::MODE_LOAD;
    logic [3:0]  i_block_index = '0;
    logic [15:0] i_amount = '0;
    logic        o_done;
    logic        o_granted;
    logic [3:0]  o_chosen_block;
    logic [15:0] o_size_left;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_alloc_tracker tracker;
    int             reg_writes = 0;

    fit_policy_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_block_index  (i_block_index),
        .i_amount       (i_amount),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_chosen_block (o_chosen_block),
        .o_size_left    (o_size_left),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result(t_alloc_result'{o_granted, o_chosen_block, o_size_left});
        if (i_rst_n && start && !busy)
            tracker.note_command(i_mode, i_block_index, i_amount);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d results outstanding", tracker.pending());
        $display("end of test: mismatches");
        $finish;
    end

    // start stays high after acceptance, the caller drives the next command or drops it
    task automatic send_command(logic mode, logic [3:0] idx, logic [15:0] amt);
        start         <= 1'b1;
        i_mode        <= mode;
        i_block_index <= idx;
        i_amount      <= amt;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic which, logic [4:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == fpba_pkg::REG_FIT_POLICY)
            tracker.policy = value[1:0];
        else
            tracker.count = value;
        reg_writes++;
    endtask

    task automatic random_command();
        logic        mode;
        logic [3:0]  idx;
        logic [15:0] amt;
        logic [15:0] v;
        int          reach;
        reach = (tracker.count == 0) ? 1 :
                (tracker.count > fpba_pkg::MAX_BLOCKS) ? fpba_pkg::MAX_BLOCKS : tracker.count;
        mode  = ($urandom_range(0, 99) < 40) ? fpba_pkg::MODE_LOAD : fpba_pkg::MODE_ALLOC;
        idx   = 4'($urandom_range(0, 15));
        if (mode == fpba_pkg::MODE_LOAD) begin
            // keep most loads inside the searched range
            if ($urandom_range(0, 1) == 0)
                idx = 4'($urandom_range(0, reach - 1));
            case ($urandom_range(0, 7))
                0:       amt = '0;
                1:       amt = '1;
                default: amt = 16'($urandom_range(0, 65535));
            endcase
        end else begin
            v = tracker.free_size[$urandom_range(0, reach - 1)];
            case ($urandom_range(0, 7))
                0:       amt = '0;
                1:       amt = 16'($urandom_range(0, 65535));
                2:       amt = 16'($urandom_range(0, 255));
                3:       amt = v;
                4:       amt = v + 16'd1;
                default: amt = 16'($urandom_range(0, v));
            endcase
        end
        send_command(mode, idx, amt);
    endtask

    initial begin
        int burst_odds;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: zero request fits block 0, anything else misses
        send_command(fpba_pkg::MODE_ALLOC, 4'd7, 16'd0);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd1);
        send_command(fpba_pkg::MODE_LOAD, 4'd0, 16'd100);
        send_command(fpba_pkg::MODE_LOAD, 4'd1, 16'd50);
        send_command(fpba_pkg::MODE_LOAD, 4'd2, 16'd200);
        send_command(fpba_pkg::MODE_LOAD, 4'd3, 16'd50);
        send_command(fpba_pkg::MODE_LOAD, 4'd4, 16'd0);
        send_command(fpba_pkg::MODE_LOAD, 4'd15, 16'hFFFF);
        send_command(fpba_pkg::MODE_ALLOC, 4'd15, 16'hFFFF);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd40);
        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POLICY_BEST));
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd45);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POLICY_WORST));
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd10);
        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(POLICY_SPARE));
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd10);
        write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd0);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd31);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        write_reg(fpba_pkg::REG_FIT_POLICY, 5'(fpba_pkg::POLICY_WORST));
        write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd1);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd51);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'd50);
        write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd16);
        send_command(fpba_pkg::MODE_LOAD, 4'd15, 16'hFFFF);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'hFFFF);
        send_command(fpba_pkg::MODE_LOAD, 4'd8, 16'h5AA5);
        send_command(fpba_pkg::MODE_ALLOC, 4'd0, 16'hFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(fpba_pkg::REG_FIT_POLICY, (p < 4) ? 5'(p) : 5'($urandom_range(0, 3)));
            case ($urandom_range(0, 5))
                0:       write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd1);
                1:       write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'd16);
                2:       write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'($urandom_range(0, 31)));
                default: write_reg(fpba_pkg::REG_BLOCK_COUNT, 5'($urandom_range(2, 16)));
            endcase
            // some phases, the last among them, run back to back
            burst_odds = (p % 3 == 1 || p == RANDOM_PHASES - 1) ? 0 : 25;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_command();
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain();
                else if ($urandom_range(0, 99) < burst_odds)
                    hold_off($urandom_range(1, 8));
            end
        end

        drain();
        repeat (fpba_pkg::ALLOC_DELAY + 2) @(posedge i_clk);
        $display("covered %0d loads and %0d allocations, %0d granted, across %0d register writes",
                 tracker.loads, tracker.allocs, tracker.grants, reg_writes);
        $display("all four policy codes, plus block counts of zero, one, full and above the table");
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
